### sv/fir12_pkg.sv
// Shared types and constants of the 12-tap FIR filter.
package fir12_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int ACC_W         = 36;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int COEF_REGS     = 3;
  localparam int COEFS_PER_REG = CFG_W / COEF_W;
  localparam int COEF_COUNT    = COEF_REGS * COEFS_PER_REG;
  localparam int ROUND_SHIFT   = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH = 2'd2;

  // Per-cell control: pipeline advance, history shift and frame clear.
  typedef struct packed {
    logic advance;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### sv/fir12_cell.sv
// One filter cell: a history sample register and a registered tap product.
module fir12_cell
  import fir12_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] x_in,
  input  logic signed [COEF_W-1:0]   coef,
  output logic signed [SAMPLE_W-1:0] x_out,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [SAMPLE_W-1:0] operand;
  logic signed [PROD_W-1:0]   prod_next;

  // A frame start drops the older sample seen from the left neighbor.
  assign operand   = ctrl.clear ? '0 : x_in;
  assign prod_next = operand * coef;

  // The operand used now is this cell's history for the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_out <= '0;
    end else if (ctrl.shift) begin
      x_out <= operand;
    end
  end

  // Product register moves with the pipeline.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod <= prod_next;
    end
  end

endmodule

### sv/fir12_tree.sv
// Registered adder tree that sums the tap products, one level per cycle while advance is high.
module fir12_tree
  import fir12_pkg::*;
#(
  parameter int N = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     in_valid,
  input  logic signed [PROD_W-1:0] leaves [N],
  output logic                     sum_valid,
  output logic signed [ACC_W-1:0]  sum
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int PAD    = 1 << LEVELS;

  // Leaves of the tree; node n sums nodes 2n and 2n+1, and the bottom level reads the leaves.
  logic signed [ACC_W-1:0] leaf [PAD];
  logic signed [ACC_W-1:0] node [1:PAD-1];
  logic [LEVELS-1:0]       vld;

  // Leaves are sign-extended; padding leaves are zero.
  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < N) begin : g_real
      assign leaf[i] = {{(ACC_W-PROD_W){leaves[i][PROD_W-1]}}, leaves[i]};
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Each level halves the number of partial sums.
  for (genvar n = 1; n < PAD; n++) begin : g_node
    if (n >= PAD / 2) begin : g_bottom
      always_ff @(posedge clk) begin
        if (advance) begin
          node[n] <= leaf[2*n-PAD] + leaf[2*n+1-PAD];
        end
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        if (advance) begin
          node[n] <= node[2*n] + node[2*n+1];
        end
      end
    end
  end

  // Valid flags follow the partial sums level by level.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= (vld << 1) | LEVELS'(in_valid);
    end
  end

  assign sum       = node[1];
  assign sum_valid = vld[LEVELS-1];

endmodule

### sv/fir12_round.sv
// Output stage: round half up to Q1.15, saturate, and hold the result.
module fir12_round
  import fir12_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       sum_valid,
  input  logic signed [ACC_W-1:0]    sum,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       saturated
);

  localparam int RND_W = ACC_W + 1 - ROUND_SHIFT;

  logic signed [ACC_W:0]          biased;
  logic signed [RND_W-1:0]        rounded;
  logic                           over;
  logic signed [SAMPLE_W-1:0]     filtered_next;

  // Add half an LSB, then floor by an arithmetic shift.
  assign biased  = {sum[ACC_W-1], sum} + (ACC_W+1)'(1 << (ROUND_SHIFT - 1));
  assign rounded = biased[ACC_W:ROUND_SHIFT];

  // The value fits when all bits above the sign bit of the result agree with it.
  assign over = (rounded[RND_W-1:SAMPLE_W-1] != '0) &&
                (rounded[RND_W-1:SAMPLE_W-1] != '1);

  always_comb begin
    if (!over) begin
      filtered_next = rounded[SAMPLE_W-1:0];
    end else if (rounded[RND_W-1]) begin
      filtered_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      filtered_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered  <= filtered_next;
      saturated <= over;
    end
  end

endmodule

### sv/fir_filter_12_tap_unit.sv
// Direct-form FIR filter: a chain of tap cells, a registered adder tree and an output stage.
// Throughput: one sample request per cycle; the whole pipeline stalls only when the output waits.
// An accepted sample passes the product registers, the adder tree levels and the output register in turn.
// Reset clears the sample history, the coefficients and all valid flags.
// Configuration writes are taken in every cycle.
module fir_filter_12_tap_unit
  import fir12_pkg::*;
#(
  parameter int TAPS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic [CFG_W-1:0]           coef_regs [COEF_REGS];
  logic                       advance;
  logic                       accept;
  logic                       prod_valid;
  logic signed [SAMPLE_W-1:0] chain [TAPS+1];
  logic signed [PROD_W-1:0]   prods [TAPS];
  logic                       sum_valid;
  logic signed [ACC_W-1:0]    sum;

  // The pipeline moves whenever the output register is free or being emptied.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && advance;
  assign cfg_ready = 1'b1;

  // Coefficient registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < COEF_REGS; r++) begin
        coef_regs[r] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_LOW:  coef_regs[0] <= cfg_data;
        REG_COEF_MID:  coef_regs[1] <= cfg_data;
        REG_COEF_HIGH: coef_regs[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid flag of the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= accept;
    end
  end

  assign chain[0] = sample;

  // Tap cells; taps past the twelfth have a zero coefficient.
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    cell_ctrl_t                 ctrl;
    logic signed [COEF_W-1:0]   coef;

    assign ctrl.advance = advance;
    assign ctrl.shift   = accept;
    assign ctrl.clear   = (k != 0) && frame_start;

    if (k < COEF_COUNT) begin : g_coef
      assign coef = coef_regs[k / COEFS_PER_REG][COEF_W*(k % COEFS_PER_REG) +: COEF_W];
    end else begin : g_zero
      assign coef = '0;
    end

    fir12_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .x_in  (chain[k]),
      .coef  (coef),
      .x_out (chain[k+1]),
      .prod  (prods[k])
    );
  end

  fir12_tree #(
    .N (TAPS)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (prod_valid),
    .leaves    (prods),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  fir12_round u_round (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sum_valid (sum_valid),
    .sum       (sum),
    .out_valid (out_valid),
    .filtered  (filtered),
    .saturated (saturated)
  );

endmodule
